@@ hdl/vnorm_pkg.sv @@
// shared constants and types for the vector normaliser
package vnorm_pkg;

    // number of result bits found by the reciprocal search, one per lane stage
    localparam int unsigned Q_BITS = 16;

    // +1.0 in q1.15 and the largest positive code
    localparam logic [Q_BITS:0]   Q_ONE   = 17'd32768;
    localparam logic [Q_BITS-1:0] Q_MAXPOS = 16'd32767;

    // number of front stages (sign and square, then sum of squares)
    localparam int unsigned FRONT_STAGES = 2;

    // result code type
    typedef logic signed [Q_BITS-1:0] q15_t;

endpackage

@@ hdl/vnorm_front.sv @@
// sign, square and sum of squares stages of the vector normaliser
module vnorm_front
    import vnorm_pkg::*;
#(
    parameter int unsigned IN_WIDTH = 16
)
(
    input  logic                      clk,
    input  logic [FRONT_STAGES-1:0]   ld,
    input  logic [IN_WIDTH-1:0]       x_in,
    input  logic [IN_WIDTH-1:0]       y_in,
    input  logic [IN_WIDTH-1:0]       z_in,
    output logic [2:0]                neg,
    output logic [2*IN_WIDTH-1:0]     msq [3],
    output logic [2*IN_WIDTH-1:0]     sumsq
);

    localparam int unsigned SW = 2 * IN_WIDTH;

    logic [IN_WIDTH-1:0] raw [3];
    logic [2:0]          neg1_reg;
    logic [SW-1:0]       sq1_reg [3];
    logic [2:0]          neg2_reg;
    logic [SW-1:0]       sq2_reg [3];
    logic [SW-1:0]       sum2_reg;
    logic [SW-1:0]       sum_next;

    assign raw[0] = x_in;
    assign raw[1] = y_in;
    assign raw[2] = z_in;

    // stage one: sign and square of each component
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg1_reg[i] <= raw[i][IN_WIDTH-1];
                sq1_reg[i]  <= SW'($signed(raw[i])) * SW'($signed(raw[i]));
            end
        end
    end

    // sum of squares, cannot overflow the double width
    assign sum_next = sq1_reg[0] + sq1_reg[1] + sq1_reg[2];

    // stage two: sum of squares
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            neg2_reg <= neg1_reg;
            sq2_reg  <= sq1_reg;
            sum2_reg <= sum_next;
        end
    end

    assign neg   = neg2_reg;
    assign msq   = sq2_reg;
    assign sumsq = sum2_reg;

endmodule

@@ hdl/vnorm_lane.sv @@
// one lane: bit-per-stage search for round(m * 32768 / sqrt(s))
module vnorm_lane
    import vnorm_pkg::*;
#(
    parameter int unsigned IN_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic [Q_BITS-1:0]     ld,
    input  logic [2*IN_WIDTH-1:0] msq,
    input  logic [2*IN_WIDTH-1:0] sumsq,
    input  logic                  neg,
    output logic [Q_BITS-1:0]     q,
    output logic                  q_neg
);

    localparam int unsigned SW = 2 * IN_WIDTH;
    localparam int unsigned PW = SW + 34;

    // per stage: result so far, (2q-1)^2*s, (2q-1)*s, bound m^2*2^32, s, sign
    logic [Q_BITS-1:0]    q_reg   [Q_BITS];
    logic signed [PW-1:0] p_reg   [Q_BITS];
    logic signed [PW-1:0] d_reg   [Q_BITS];
    logic signed [PW-1:0] rhs_reg [Q_BITS];
    logic signed [PW-1:0] s_reg   [Q_BITS];
    logic                 neg_reg [Q_BITS];

    genvar j;
    generate
        for (j = 0; j < Q_BITS; j++)
        begin : g_stage
            localparam int unsigned B = Q_BITS - 1 - j;

            logic [Q_BITS-1:0]    q_prev;
            logic signed [PW-1:0] p_prev;
            logic signed [PW-1:0] d_prev;
            logic signed [PW-1:0] rhs_prev;
            logic signed [PW-1:0] s_prev;
            logic                 neg_prev;
            logic [Q_BITS:0]      cand;
            logic signed [PW-1:0] p_cand;
            logic                 take;

            // lane entry starts from q = 0, where 2q-1 = -1
            if (j == 0)
            begin : g_entry
                assign q_prev   = '0;
                assign s_prev   = PW'($signed({1'b0, sumsq}));
                assign p_prev   = s_prev;
                assign d_prev   = -s_prev;
                assign rhs_prev = PW'($signed({1'b0, msq, 32'd0}));
                assign neg_prev = neg;
            end
            else
            begin : g_chain
                assign q_prev   = q_reg[j-1];
                assign p_prev   = p_reg[j-1];
                assign d_prev   = d_reg[j-1];
                assign rhs_prev = rhs_reg[j-1];
                assign s_prev   = s_reg[j-1];
                assign neg_prev = neg_reg[j-1];
            end

            // trial bit: (2q-1+2^(b+1))^2*s by shifts and adds
            assign cand   = {1'b0, q_prev} + (17'd1 << B);
            assign p_cand = p_prev + (d_prev <<< (B + 2)) + (s_prev <<< (2 * B + 2));
            assign take   = (cand <= Q_ONE) && (p_cand <= rhs_prev);

            always_ff @(posedge clk)
            begin
                if (ld[j])
                begin
                    q_reg[j]   <= take ? cand[Q_BITS-1:0] : q_prev;
                    p_reg[j]   <= take ? p_cand : p_prev;
                    d_reg[j]   <= take ? (d_prev + (s_prev <<< (B + 1))) : d_prev;
                    rhs_reg[j] <= rhs_prev;
                    s_reg[j]   <= s_prev;
                    neg_reg[j] <= neg_prev;
                end
            end
        end
    endgenerate

    assign q     = q_reg[Q_BITS-1];
    assign q_neg = neg_reg[Q_BITS-1];

endmodule

@@ hdl/vector3_normalizer.sv @@
// top level of the three-component vector normaliser
//
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall  | x_in, y_in, z_in
//  out     | out of    | out_valid/out_stall| x_out, y_out, z_out, was_zero
//
// two front stages, 16 lane stages (one result bit each), one merging stage;
// one transfer per cycle sustained in and out while out_stall is low.
// every stage has its own valid bit, so bubbles close up under a stall and a
// new item is taken while a finished result waits at the output register.
// reset clears the valid bits only; the data registers are not reset.
module vector3_normalizer
    import vnorm_pkg::*;
#(
    parameter int unsigned IN_WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [IN_WIDTH-1:0] x_in,
    input  logic [IN_WIDTH-1:0] y_in,
    input  logic [IN_WIDTH-1:0] z_in,
    output logic                out_valid,
    input  logic                out_stall,
    output q15_t                x_out,
    output q15_t                y_out,
    output q15_t                z_out,
    output logic                was_zero
);

    localparam int unsigned SW = 2 * IN_WIDTH;
    localparam int unsigned NST = FRONT_STAGES + Q_BITS + 1;
    localparam int unsigned LAST = NST - 1;

    logic [NST-1:0]      v_reg;
    logic [NST-1:0]      v_next;
    logic [NST-1:0]      free;
    logic [2:0]          neg;
    logic [SW-1:0]       msq [3];
    logic [SW-1:0]       sumsq;
    logic [Q_BITS-1:0]   lq   [3];
    logic [2:0]          lneg;
    logic                zero_reg [Q_BITS];
    q15_t                res_next [3];
    q15_t                res_reg  [3];
    logic                zflag_reg;

    // a stage may load when empty or when its content moves on
    always_comb
    begin
        free[LAST] = !v_reg[LAST] || !out_stall;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            free[i] = !v_reg[i] || free[i+1];
        end
    end

    always_comb
    begin
        v_next = v_reg;
        for (int i = 0; i < NST; i++)
        begin
            if (free[i])
            begin
                v_next[i] = (i == 0) ? in_valid : v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !free[0];
    assign out_valid = v_reg[LAST];

    // front: signs, squares and sum of squares
    vnorm_front #(.IN_WIDTH(IN_WIDTH)) u_front (
        .clk   (clk),
        .ld    (free[FRONT_STAGES-1:0]),
        .x_in  (x_in),
        .y_in  (y_in),
        .z_in  (z_in),
        .neg   (neg),
        .msq   (msq),
        .sumsq (sumsq)
    );

    // three lanes side by side
    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_lane
            vnorm_lane #(.IN_WIDTH(IN_WIDTH)) u_lane (
                .clk   (clk),
                .ld    (free[FRONT_STAGES +: Q_BITS]),
                .msq   (msq[k]),
                .sumsq (sumsq),
                .neg   (neg[k]),
                .q     (lq[k]),
                .q_neg (lneg[k])
            );
        end
    endgenerate

    // zero-vector flag travels alongside the lanes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_BITS; i++)
        begin
            if (free[FRONT_STAGES + i])
            begin
                zero_reg[i] <= (i == 0) ? (sumsq == '0) : zero_reg[i-1];
            end
        end
    end

    // merging stage: sign, saturation and zero override
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg[Q_BITS-1])
            begin
                res_next[i] = '0;
            end
            else if (lneg[i])
            begin
                res_next[i] = q15_t'(~lq[i] + 1'b1);
            end
            else if (lq[i] > Q_MAXPOS)
            begin
                res_next[i] = q15_t'(Q_MAXPOS);
            end
            else
            begin
                res_next[i] = q15_t'(lq[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free[LAST])
        begin
            res_reg   <= res_next;
            zflag_reg <= zero_reg[Q_BITS-1];
        end
    end

    assign x_out    = res_reg[0];
    assign y_out    = res_reg[1];
    assign z_out    = res_reg[2];
    assign was_zero = zflag_reg;

    // an empty output register means the whole chain can take an item
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // a zero vector gives zero components
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_zero) |-> (x_out == 0 && y_out == 0 && z_out == 0))
        else $error("zero vector with non-zero result");

    // a non-zero vector gives at least one non-zero component
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !was_zero) |-> !(x_out == 0 && y_out == 0 && z_out == 0))
        else $error("non-zero vector normalised to zero");

endmodule

@@ tb/sv/tb.sv @@
// testbench for the three-component vector normaliser
`timescale 1ns / 100ps

module tb;
    import vnorm_pkg::*;

    localparam int unsigned WIDTH = 16;
    localparam int unsigned LATENCY = 19;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        q15_t x;
        q15_t y;
        q15_t z;
        logic zero;
    } unit_vec_t;

    typedef struct {
        logic [WIDTH-1:0] x;
        logic [WIDTH-1:0] y;
        logic [WIDTH-1:0] z;
        logic             known;
        unit_vec_t        res;
    } vec_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [WIDTH-1:0] x_in;
    logic [WIDTH-1:0] y_in;
    logic [WIDTH-1:0] z_in;
    logic             out_valid;
    logic             out_stall;
    q15_t             x_out;
    q15_t             y_out;
    q15_t             z_out;
    logic             was_zero;

    unit_vec_t    pending_units[$];
    int unsigned  error_count;
    int unsigned  cycle_count;
    int unsigned  sent_count;
    int unsigned  recv_count;
    int unsigned  zero_count;
    int unsigned  sat_count;
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    bit           hold_off;
    vec_row_t     directed[$];

    vector3_normalizer #(.IN_WIDTH(WIDTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_in      (x_in),
        .y_in      (y_in),
        .z_in      (z_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x_out     (x_out),
        .y_out     (y_out),
        .z_out     (z_out),
        .was_zero  (was_zero)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // largest q in [0, 32768] with (2q-1)^2 * s <= m^2 * 2^32
    function automatic longint unsigned round_scaled(longint unsigned m, longint unsigned s);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        logic [127:0]    lhs;
        logic [127:0]    rhs;
        lo = 0;
        hi = 32768;
        rhs = 128'(m * m) << 32;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            lhs = 128'((2 * mid - 1) * (2 * mid - 1)) * 128'(s);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic q15_t component_q15(longint unsigned m, bit neg, longint unsigned s);
        longint unsigned q;
        q = round_scaled(m, s);
        if (neg)
            return q15_t'(-q);
        if (q > 32767)
            q = 32767;
        return q15_t'(q);
    endfunction

    function automatic unit_vec_t normalise(logic [WIDTH-1:0] xv, logic [WIDTH-1:0] yv,
                                            logic [WIDTH-1:0] zv);
        logic [WIDTH-1:0] comp[3];
        longint unsigned  mag[3];
        bit               neg[3];
        longint unsigned  s;
        unit_vec_t        r;
        comp[0] = xv;
        comp[1] = yv;
        comp[2] = zv;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = comp[i][WIDTH-1];
            mag[i] = neg[i] ? (longint'(1) << WIDTH) - comp[i] : comp[i];
            s += mag[i] * mag[i];
        end
        if (s == 0)
        begin
            r.x = '0;
            r.y = '0;
            r.z = '0;
            r.zero = 1'b1;
            return r;
        end
        r.x = component_q15(mag[0], neg[0], s);
        r.y = component_q15(mag[1], neg[1], s);
        r.z = component_q15(mag[2], neg[2], s);
        r.zero = 1'b0;
        return r;
    endfunction

    function automatic vec_row_t make_row(int xv, int yv, int zv, bit known = 0,
                                          int ex = 0, int ey = 0, int ez = 0, bit ezero = 0);
        vec_row_t row;
        row.x = xv[WIDTH-1:0];
        row.y = yv[WIDTH-1:0];
        row.z = zv[WIDTH-1:0];
        row.known = known;
        row.res.x = ex[15:0];
        row.res.y = ey[15:0];
        row.res.z = ez[15:0];
        row.res.zero = ezero;
        return row;
    endfunction

    // drive one vector and wait for its transfer
    task automatic send_vector(logic [WIDTH-1:0] xv, logic [WIDTH-1:0] yv,
                               logic [WIDTH-1:0] zv, unit_vec_t expected);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        x_in <= xv;
        y_in <= yv;
        z_in <= zv;
        do
            @(posedge clk);
        while (in_stall);
        pending_units.push_back(expected);
        sent_count++;
        if (expected.zero)
            zero_count++;
        if (expected.x == Q_MAXPOS || expected.y == Q_MAXPOS || expected.z == Q_MAXPOS)
            sat_count++;
        @(negedge clk);
    endtask

    // random vector, mostly full range, sometimes small or axis-aligned
    task automatic send_random();
        logic [WIDTH-1:0] v[3];
        int unsigned      kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 3; i++)
        begin
            case (kind)
                0, 1: v[i] = WIDTH'($urandom_range(8) - 4);
                2:    v[i] = ($urandom_range(2) == 0) ? WIDTH'($urandom) : '0;
                3:    v[i] = ($urandom_range(1) == 0) ? 16'h8000 : WIDTH'($urandom_range(3));
                default: v[i] = WIDTH'($urandom);
            endcase
        end
        send_vector(v[0], v[1], v[2], normalise(v[0], v[1], v[2]));
    endtask

    // receiver stall, with a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        unit_vec_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            recv_count++;
            if (pending_units.size() == 0)
            begin
                $error("result with nothing expected: x_out %0d", x_out);
                error_count++;
            end
            else
            begin
                e = pending_units.pop_front();
                if (x_out !== e.x)
                begin
                    $error("x_out expected %0d actual %0d", e.x, x_out);
                    error_count++;
                end
                if (y_out !== e.y)
                begin
                    $error("y_out expected %0d actual %0d", e.y, y_out);
                    error_count++;
                end
                if (z_out !== e.z)
                begin
                    $error("z_out expected %0d actual %0d", e.z, z_out);
                    error_count++;
                end
                if (was_zero !== e.zero)
                begin
                    $error("was_zero expected %0d actual %0d", e.zero, was_zero);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // long receiver hold-off, counted here while the sender keeps offering
    task automatic receiver_hold(int unsigned cycles);
        hold_off = 1'b1;
        repeat (cycles) @(negedge clk);
        hold_off = 1'b0;
    endtask

    initial
    begin
        unit_vec_t e;
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_in = '0;
        y_in = '0;
        z_in = '0;
        hold_off = 1'b0;
        error_count = 0;
        cycle_count = 0;
        sent_count = 0;
        recv_count = 0;
        zero_count = 0;
        sat_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed table: zero vector, axes, full scale, ties and width extremes
        directed.push_back(make_row(0, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_row(1, 0, 0, 1, 32767, 0, 0, 0));
        directed.push_back(make_row(0, -1, 0, 1, 0, -32768, 0, 0));
        directed.push_back(make_row(0, 0, 32767, 1, 0, 0, 32767, 0));
        directed.push_back(make_row(-32768, 0, 0, 1, -32768, 0, 0, 0));
        directed.push_back(make_row(0, 0, -32768, 1, 0, 0, -32768, 0));
        directed.push_back(make_row(3, 4, 0));
        directed.push_back(make_row(-3, 0, 4));
        directed.push_back(make_row(1, 1, 0));
        directed.push_back(make_row(1, 1, 1));
        directed.push_back(make_row(-1, -1, -1));
        directed.push_back(make_row(32767, 32767, 32767));
        directed.push_back(make_row(-32768, -32768, -32768));
        directed.push_back(make_row(32767, -32768, 1));
        directed.push_back(make_row(2, 3, 6));
        directed.push_back(make_row(-32768, 32767, 0));
        directed.push_back(make_row(1, 0, -32768));
        directed.push_back(make_row(16'h5555, 16'hAAAA, 16'h0F0F));
        directed.push_back(make_row(16'hAAAA, 16'h5555, 16'hF0F0));
        directed.push_back(make_row(12345, -23456, 7));
        foreach (directed[i])
        begin
            e = directed[i].known ? directed[i].res
                                  : normalise(directed[i].x, directed[i].y, directed[i].z);
            send_vector(directed[i].x, directed[i].y, directed[i].z, e);
        end

        // random part in three idling phases, long hold-off in the first
        send_idle_pct = 34;
        recv_idle_pct = 85;
        fork
            receiver_hold(300);
            repeat (60) send_random();
        join
        repeat (500) send_random();
        send_idle_pct = 85;
        recv_idle_pct = 34;
        repeat (560) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (580) send_random();
        in_valid <= 1'b0;

        // drain
        while (pending_units.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);

        $display("sent %0d vectors, %0d results checked", sent_count, recv_count);
        $display("zero vectors %0d, results with a saturated component %0d",
                 zero_count, sat_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ vector3_normalizer.f @@
hdl/vnorm_pkg.sv
hdl/vnorm_front.sv
hdl/vnorm_lane.sv
hdl/vector3_normalizer.sv
tb/sv/tb.sv
